FILE: rtl/phwp_pkg.sv
// Shared widths, codes and pipeline payload types of the pair force block.
package phwp_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_W      = WORD_W - 1;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int SQ_REM_W   = WORD_W + 2;
    localparam int SQRT_STEPS = WORD_W;
    localparam int DIV_STEPS  = WORD_W;
    localparam int WIDE_STEPS = CFG_W + FRAC_W + 1;
    localparam int KC_W       = 2 * CFG_W;
    localparam int P_W        = KC_W - FRAC_W;
    localparam int PHI_W      = P_W - WORD_W;
    localparam int E_W        = P_W + CFG_W;
    localparam int E17_W      = E_W - FRAC_W - 1;

    localparam logic [WORD_W-1:0] SAT_MAX     = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN_MAG = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REGION_REPULSE,
        REGION_INNER,
        REGION_OUTER,
        REGION_BEYOND
    } region_t;

    typedef enum logic [1:0] {
        REG_DESIRED,
        REG_CUTOFF,
        REG_SPRING,
        REG_DEPTH
    } reg_idx_t;

    // Per-item data that travels alongside the arithmetic cells.
    typedef struct packed {
        logic [2:0][WORD_W-1:0] mag;
        logic [2:0]             neg;
        logic [WORD_W-1:0]      span;
        region_t                region;
        logic [CFG_W-1:0]       tv;
        logic [WORD_W-1:0]      energy;
        logic [WORD_W-1:0]      fmag;
        logic                   fneg;
        logic [CFG_W-1:0]       m1;
    } side_t;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] force_v;
        logic [WORD_W-1:0]      energy;
        region_t                region;
    } result_t;

endpackage

FILE: rtl/phwp_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module phwp_sqrt_cell import phwp_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [PROD_W-1:0]   rad_i,
    input  logic [SQ_REM_W-1:0] rem_i,
    input  logic [WORD_W-1:0]   root_i,
    output logic [PROD_W-1:0]   rad_o,
    output logic [SQ_REM_W-1:0] rem_o,
    output logic [WORD_W-1:0]   root_o
);

    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] trial;
    logic                fit;
    logic [PROD_W-1:0]   rad_reg, rad_next;
    logic [SQ_REM_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0]   root_reg, root_next;

    always_comb begin
        acc       = {rem_i, rad_i[PROD_W-1 -: 2]};
        trial     = {{(SQ_REM_W-WORD_W){1'b0}}, root_i, 2'b01};
        fit       = (acc >= trial);
        rad_next  = {rad_i[PROD_W-3:0], 2'b00};
        rem_next  = fit ? SQ_REM_W'(acc - trial) : acc[SQ_REM_W-1:0];
        root_next = {root_i[WORD_W-2:0], fit};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

FILE: rtl/phwp_div_cell.sv
// One restoring division step: shift in a dividend bit, subtract if it fits.
module phwp_div_cell import phwp_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [WORD_W-1:0] div_i,
    input  logic [WORD_W-1:0] rem_i,
    input  logic [PROD_W-1:0] dq_i,
    output logic [WORD_W-1:0] rem_o,
    output logic [PROD_W-1:0] dq_o
);

    logic [WORD_W:0]   acc;
    logic              fit;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] dq_reg, dq_next;

    always_comb begin
        acc      = {rem_i, dq_i[PROD_W-1]};
        fit      = (acc >= {1'b0, div_i});
        rem_next = fit ? WORD_W'(acc - {1'b0, div_i}) : acc[WORD_W-1:0];
        dq_next  = {dq_i[PROD_W-2:0], fit};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign rem_o = rem_reg;
    assign dq_o  = dq_reg;

endmodule

FILE: rtl/phwp_side_stage.sv
// Valid bit and item payload register for one pipeline position.
module phwp_side_stage import phwp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  vld_i,
    input  side_t side_i,
    output logic  vld_o,
    output side_t side_o
);

    logic  vld_reg;
    side_t side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_i;
        end
    end

    assign vld_o  = vld_reg;
    assign side_o = side_reg;

endmodule

FILE: rtl/phwp_out_buf.sv
// Output register with one skid entry behind it.
module phwp_out_buf import phwp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data,
    output logic    full
);

    logic    out_vld_reg;
    logic    skid_vld_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop = out_vld_reg & out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            priority if (pop) begin
                if (skid_vld_reg) begin
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg <= push;
                end
            end else if (push) begin
                if (out_vld_reg) begin
                    skid_vld_reg <= 1'b1;
                end else begin
                    out_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_vld_reg) begin
            out_reg <= skid_reg;
        end else if (push && (pop || !out_vld_reg)) begin
            out_reg <= push_data;
        end
        if (push && out_vld_reg && !pop) begin
            skid_reg <= push_data;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
    assign full      = skid_vld_reg;

endmodule

FILE: rtl/piecewise_harmonic_pair_force.sv
// Top level: piecewise harmonic pair energy and force, one pair per cycle while the row is not halted.
//
//  channel | ports                                         | role
//  --------+-----------------------------------------------+------------------
//  input   | s_valid s_ready s_sep_x s_sep_y s_sep_z       | separation vector
//  result  | m_valid m_ready m_force_x/y/z m_pair_energy   | force and energy
//          | m_region                                      |
//  config  | cfg_valid cfg_ready cfg_index cfg_data        | register write
//
// One beat is taken per cycle while the row advances; the path from input beat to result beat runs
// through the row of root cells, two chained 48-step divider rows and the 32-step force row.
// Reset loads the register defaults and empties the row; config writes are taken at once.
// The row halts only while the skid entry behind the output register is occupied.
module piecewise_harmonic_pair_force import phwp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [WORD_W-1:0] s_sep_x,
    input  logic signed [WORD_W-1:0] s_sep_y,
    input  logic signed [WORD_W-1:0] s_sep_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [WORD_W-1:0] m_force_x,
    output logic signed [WORD_W-1:0] m_force_y,
    output logic signed [WORD_W-1:0] m_force_z,
    output logic signed [WORD_W-1:0] m_pair_energy,
    output logic [1:0]               m_region,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [WORD_W-1:0]        cfg_data
);

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] des_reg, cut_reg, k_reg, dep_reg;
    logic [CFG_W-1:0] len_w;
    logic [WORD_W-1:0] len_div;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            des_reg <= CFG_W'(1) << FRAC_W;
            cut_reg <= CFG_W'(2) << FRAC_W;
            k_reg   <= CFG_W'(1) << FRAC_W;
            dep_reg <= CFG_W'(1) << FRAC_W;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_DESIRED: des_reg <= cfg_data[CFG_W-1:0];
                REG_CUTOFF:  cut_reg <= cfg_data[CFG_W-1:0];
                REG_SPRING:  k_reg   <= cfg_data[CFG_W-1:0];
                REG_DEPTH:   dep_reg <= cfg_data[CFG_W-1:0];
            endcase
        end
    end

    assign len_w   = cut_reg - des_reg;
    assign len_div = {1'b0, len_w};

    // ---------------- flow control ----------------
    logic adv;
    logic buf_full;

    assign adv     = !buf_full;
    assign s_ready = adv;

    // ---------------- front: magnitudes, squares, sum ----------------
    logic [2:0][WORD_W-1:0] sep_in;
    logic [2:0][WORD_W-1:0] mag_in;
    logic [2:0]             neg_in;

    assign sep_in[0] = s_sep_x;
    assign sep_in[1] = s_sep_y;
    assign sep_in[2] = s_sep_z;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            neg_in[c] = sep_in[c][WORD_W-1];
            mag_in[c] = neg_in[c] ? ('0 - sep_in[c]) : sep_in[c];
        end
    end

    logic                   v1_reg, v2_reg, v3_reg;
    logic [2:0][WORD_W-1:0] mag1_reg, mag2_reg;
    logic [2:0]             neg1_reg, neg2_reg;
    logic [2:0][PROD_W-1:0] sq2_reg;
    logic [PROD_W-1:0]      sum3_reg;
    side_t                  side3_reg;
    side_t                  side3_next;

    always_comb begin
        side3_next     = '0;
        side3_next.mag = mag2_reg;
        side3_next.neg = neg2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg <= mag_in;
            neg1_reg <= neg_in;
            for (int c = 0; c < 3; c++) begin
                sq2_reg[c] <= {{WORD_W{1'b0}}, mag1_reg[c]} * {{WORD_W{1'b0}}, mag1_reg[c]};
            end
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            sum3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            side3_reg <= side3_next;
        end
    end

    // ---------------- root row ----------------
    logic                vq   [0:SQRT_STEPS];
    side_t               sq_s [0:SQRT_STEPS];
    logic [PROD_W-1:0]   sq_rad  [0:SQRT_STEPS];
    logic [SQ_REM_W-1:0] sq_rem  [0:SQRT_STEPS];
    logic [WORD_W-1:0]   sq_root [0:SQRT_STEPS];

    assign vq[0]      = v3_reg;
    assign sq_s[0]    = side3_reg;
    assign sq_rad[0]  = sum3_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        phwp_sqrt_cell u_cell (
            .aclk   (aclk),
            .en     (adv),
            .rad_i  (sq_rad[i]),
            .rem_i  (sq_rem[i]),
            .root_i (sq_root[i]),
            .rad_o  (sq_rad[i+1]),
            .rem_o  (sq_rem[i+1]),
            .root_o (sq_root[i+1])
        );
        phwp_side_stage u_side (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (vq[i]),
            .side_i  (sq_s[i]),
            .vld_o   (vq[i+1]),
            .side_o  (sq_s[i+1])
        );
    end

    // ---------------- classify, products, repulsive energy ----------------
    logic [WORD_W-1:0] dist_w;
    side_t             side4_next;
    logic [CFG_W-1:0]  d_in;

    assign dist_w = sq_root[SQRT_STEPS];

    always_comb begin
        side4_next      = sq_s[SQRT_STEPS];
        side4_next.span = dist_w;
        d_in            = dist_w[CFG_W-1:0] - des_reg;
        if (dist_w < {1'b0, des_reg}) begin
            side4_next.region = REGION_REPULSE;
            side4_next.tv     = des_reg - dist_w[CFG_W-1:0];
        end else if (dist_w < {1'b0, cut_reg}) begin
            if ({d_in, 1'b0} < {1'b0, len_w}) begin
                side4_next.region = REGION_INNER;
                side4_next.tv     = d_in;
            end else begin
                side4_next.region = REGION_OUTER;
                side4_next.tv     = cut_reg - dist_w[CFG_W-1:0];
            end
        end else begin
            side4_next.region = REGION_BEYOND;
            side4_next.tv     = '0;
        end
    end

    logic              v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    side_t             side4_reg, side5_reg, side6_reg, side7_reg, side8_reg, side9_reg;
    logic [KC_W-1:0]   kc5_reg, dt5_reg, dt6_reg, dt7_reg, dt8_reg, dt9_reg;
    logic [P_W-1:0]    p6_reg;
    logic [KC_W:0]     elo7_reg;
    logic [PHI_W+CFG_W-1:0] ehi7_reg;
    logic [E17_W-1:0]  e17_8_reg;
    logic [P_W-1:0]    p_w;
    logic [E_W-1:0]    e_sum;
    logic [E17_W:0]    e_diff;
    logic [WORD_W-1:0] e_rep;
    side_t             side6_next;
    side_t             side9_next;

    always_comb begin
        p_w        = kc5_reg[KC_W-1:FRAC_W];
        side6_next = side5_reg;
        if (side5_reg.region == REGION_REPULSE) begin
            side6_next.fneg = 1'b1;
            side6_next.fmag = (p_w > P_W'(SAT_MIN_MAG)) ? SAT_MIN_MAG : p_w[WORD_W-1:0];
        end else begin
            side6_next.fneg = 1'b0;
            side6_next.fmag = '0;
        end
        e_sum  = {ehi7_reg, {WORD_W{1'b0}}} + E_W'(elo7_reg);
        e_diff = {1'b0, e17_8_reg} - (E17_W+1)'(dep_reg);
        priority if (e_diff[E17_W]) begin
            e_rep = e_diff[WORD_W-1:0];
        end else if (e_diff[E17_W-1:0] > E17_W'(SAT_MAX)) begin
            e_rep = SAT_MAX;
        end else begin
            e_rep = e_diff[WORD_W-1:0];
        end
        side9_next        = side8_reg;
        side9_next.energy = (side8_reg.region == REGION_REPULSE) ? e_rep : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= vq[SQRT_STEPS];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side4_reg <= side4_next;
            kc5_reg   <= {{CFG_W{1'b0}}, k_reg} * {{CFG_W{1'b0}}, side4_reg.tv};
            dt5_reg   <= {{CFG_W{1'b0}}, dep_reg} * {{CFG_W{1'b0}}, side4_reg.tv};
            side5_reg <= side4_reg;
            p6_reg    <= p_w;
            dt6_reg   <= dt5_reg;
            side6_reg <= side6_next;
            elo7_reg  <= (KC_W+1)'(p6_reg[WORD_W-1:0]) * (KC_W+1)'(side6_reg.tv);
            ehi7_reg  <= (PHI_W+CFG_W)'(p6_reg[P_W-1:WORD_W]) * (PHI_W+CFG_W)'(side6_reg.tv);
            dt7_reg   <= dt6_reg;
            side7_reg <= side6_reg;
            e17_8_reg <= e_sum[E_W-1:FRAC_W+1];
            dt8_reg   <= dt7_reg;
            side8_reg <= side7_reg;
            dt9_reg   <= dt8_reg;
            side9_reg <= side9_next;
        end
    end

    // ---------------- first divider row: m1 = 2Dt/L and q1 = D*t*2^(F+2)/L ----------------
    logic              vx   [0:WIDE_STEPS];
    side_t             xs   [0:WIDE_STEPS];
    logic [WORD_W-1:0] a_rem [0:DIV_STEPS];
    logic [PROD_W-1:0] a_dq  [0:DIV_STEPS];
    logic [WORD_W-1:0] b_rem [0:WIDE_STEPS];
    logic [PROD_W-1:0] b_dq  [0:WIDE_STEPS];

    assign vx[0]    = v9_reg;
    assign xs[0]    = side9_reg;
    assign a_rem[0] = {1'b0, dt9_reg[KC_W-1:WORD_W-1]};
    assign a_dq[0]  = {dt9_reg[WORD_W-2:0], 1'b0, {WORD_W{1'b0}}};
    assign b_rem[0] = dt9_reg[KC_W-1:WIDE_STEPS-FRAC_W-2];
    assign b_dq[0]  = {dt9_reg[WIDE_STEPS-FRAC_W-3:0], {(PROD_W-WIDE_STEPS+FRAC_W+2){1'b0}}};

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_diva
        phwp_div_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .div_i (len_div),
            .rem_i (a_rem[i]),
            .dq_i  (a_dq[i]),
            .rem_o (a_rem[i+1]),
            .dq_o  (a_dq[i+1])
        );
    end

    for (genvar i = 0; i < WIDE_STEPS; i++) begin : g_divb
        side_t s_in;
        if (i == DIV_STEPS) begin : g_take
            always_comb begin
                s_in    = xs[i];
                s_in.m1 = a_dq[DIV_STEPS][CFG_W-1:0];
            end
        end else begin : g_pass
            assign s_in = xs[i];
        end
        phwp_div_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .div_i (len_div),
            .rem_i (b_rem[i]),
            .dq_i  (b_dq[i]),
            .rem_o (b_rem[i+1]),
            .dq_o  (b_dq[i+1])
        );
        phwp_side_stage u_side (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (vx[i]),
            .side_i  (s_in),
            .vld_o   (vx[i+1]),
            .side_o  (xs[i+1])
        );
    end

    // ---------------- m1 * t ----------------
    logic                  vy_reg;
    side_t                 sidey_reg;
    logic [KC_W-1:0]       mt_reg;
    logic [WIDE_STEPS-1:0] q1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vy_reg <= 1'b0;
        end else if (adv) begin
            vy_reg <= vx[WIDE_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sidey_reg <= xs[WIDE_STEPS];
            mt_reg    <= {{CFG_W{1'b0}}, xs[WIDE_STEPS].m1} * {{CFG_W{1'b0}}, xs[WIDE_STEPS].tv};
            q1_reg    <= b_dq[WIDE_STEPS][WIDE_STEPS-1:0];
        end
    end

    // ---------------- second divider row: m = m1*t/L and q2 = q1/L ----------------
    logic              vz   [0:WIDE_STEPS];
    side_t             zs   [0:WIDE_STEPS];
    logic [WORD_W-1:0] c_rem [0:DIV_STEPS];
    logic [PROD_W-1:0] c_dq  [0:DIV_STEPS];
    logic [WORD_W-1:0] d_rem [0:WIDE_STEPS];
    logic [PROD_W-1:0] d_dq  [0:WIDE_STEPS];

    assign vz[0]    = vy_reg;
    assign zs[0]    = sidey_reg;
    assign c_rem[0] = {{(PROD_W-KC_W){1'b0}}, mt_reg[KC_W-1:WORD_W]};
    assign c_dq[0]  = {mt_reg[WORD_W-1:0], {WORD_W{1'b0}}};
    assign d_rem[0] = '0;
    assign d_dq[0]  = {q1_reg, {(PROD_W-WIDE_STEPS){1'b0}}};

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_divc
        phwp_div_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .div_i (len_div),
            .rem_i (c_rem[i]),
            .dq_i  (c_dq[i]),
            .rem_o (c_rem[i+1]),
            .dq_o  (c_dq[i+1])
        );
    end

    for (genvar i = 0; i < WIDE_STEPS; i++) begin : g_divd
        side_t s_in;
        if (i == DIV_STEPS) begin : g_take
            logic [WORD_W-1:0] m_val;
            always_comb begin
                m_val = c_dq[DIV_STEPS][WORD_W-1:0];
                s_in  = zs[i];
                unique case (zs[i].region)
                    REGION_INNER:   s_in.energy = m_val - {1'b0, dep_reg};
                    REGION_OUTER:   s_in.energy = '0 - m_val;
                    REGION_REPULSE: s_in.energy = zs[i].energy;
                    REGION_BEYOND:  s_in.energy = zs[i].energy;
                endcase
            end
        end else begin : g_pass
            assign s_in = zs[i];
        end
        phwp_div_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .div_i (len_div),
            .rem_i (d_rem[i]),
            .dq_i  (d_dq[i]),
            .rem_o (d_rem[i+1]),
            .dq_o  (d_dq[i+1])
        );
        phwp_side_stage u_side (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (vz[i]),
            .side_i  (s_in),
            .vld_o   (vz[i+1]),
            .side_o  (zs[i+1])
        );
    end

    // ---------------- factor and force numerators ----------------
    logic                   vf_reg, vg_reg;
    side_t                  sidef_reg, sideg_reg;
    side_t                  sidef_next;
    logic [WIDE_STEPS-1:0]  q2_w;
    logic [2:0][PROD_W-1:0] prodg_reg;

    assign q2_w = d_dq[WIDE_STEPS][WIDE_STEPS-1:0];

    always_comb begin
        sidef_next = zs[WIDE_STEPS];
        if (zs[WIDE_STEPS].region == REGION_INNER || zs[WIDE_STEPS].region == REGION_OUTER) begin
            sidef_next.fneg = 1'b0;
            sidef_next.fmag = (q2_w > WIDE_STEPS'(SAT_MAX)) ? SAT_MAX : q2_w[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end else if (adv) begin
            vf_reg <= vz[WIDE_STEPS];
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sidef_reg <= sidef_next;
            sideg_reg <= sidef_reg;
            for (int c = 0; c < 3; c++) begin
                prodg_reg[c] <= {{WORD_W{1'b0}}, sidef_reg.fmag}
                              * {{WORD_W{1'b0}}, sidef_reg.mag[c]};
            end
        end
    end

    // ---------------- force divider row: factor*|sep|/dist, three lanes ----------------
    logic              vh   [0:DIV_STEPS];
    side_t             hs   [0:DIV_STEPS];
    logic [WORD_W-1:0] h_rem [0:2][0:DIV_STEPS];
    logic [PROD_W-1:0] h_dq  [0:2][0:DIV_STEPS];

    assign vh[0] = vg_reg;
    assign hs[0] = sideg_reg;

    for (genvar c = 0; c < 3; c++) begin : g_lane
        assign h_rem[c][0] = prodg_reg[c][PROD_W-1:WORD_W];
        assign h_dq[c][0]  = {prodg_reg[c][WORD_W-1:0], {WORD_W{1'b0}}};
        for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
            phwp_div_cell u_cell (
                .aclk  (aclk),
                .en    (adv),
                .div_i (hs[i].span),
                .rem_i (h_rem[c][i]),
                .dq_i  (h_dq[c][i]),
                .rem_o (h_rem[c][i+1]),
                .dq_o  (h_dq[c][i+1])
            );
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_hside
        phwp_side_stage u_side (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .vld_i   (vh[i]),
            .side_i  (hs[i]),
            .vld_o   (vh[i+1]),
            .side_o  (hs[i+1])
        );
    end

    // ---------------- result assembly and output buffer ----------------
    result_t           res_w;
    result_t           out_w;
    logic              no_force;
    logic [WORD_W-1:0] q_c;

    always_comb begin
        no_force      = (hs[DIV_STEPS].span == '0) || (hs[DIV_STEPS].fmag == '0);
        res_w.energy  = hs[DIV_STEPS].energy;
        res_w.region  = hs[DIV_STEPS].region;
        res_w.force_v = '0;
        for (int c = 0; c < 3; c++) begin
            q_c = h_dq[c][DIV_STEPS][WORD_W-1:0];
            if (!no_force) begin
                res_w.force_v[c] = (hs[DIV_STEPS].fneg != hs[DIV_STEPS].neg[c]) ? ('0 - q_c) : q_c;
            end
        end
    end

    phwp_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (vh[DIV_STEPS] & adv),
        .push_data (res_w),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_w),
        .full      (buf_full)
    );

    assign m_force_x     = out_w.force_v[0];
    assign m_force_y     = out_w.force_v[1];
    assign m_force_z     = out_w.force_v[2];
    assign m_pair_energy = out_w.energy;
    assign m_region      = out_w.region;

endmodule
